### sv/coprime_pair_validator_core_defines.svh
// ----------------------------------------------------------------------------
// Coprime pair validator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COPRIME_PAIR_VALIDATOR_CORE_DEFINES_SVH
`define COPRIME_PAIR_VALIDATOR_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPV_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CPV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/cpv_pkg.sv
// ----------------------------------------------------------------------------
// Coprime pair validator package
// Widths, counter indexes, controller types and shared helper functions.
// ----------------------------------------------------------------------------
package cpv_pkg;

  // Widths of the channel fields.
  localparam int PORT_VALUE_W = 64;
  localparam int PORT_COUNT_W = 32;

  // Widths used inside the datapath.
  localparam int VALUE_WIDTH = 64;
  localparam int COUNT_WIDTH = 32;
  localparam int SHIFT_W     = $clog2(VALUE_WIDTH);

  // Statistics counter slots.
  localparam int CNT_TOTAL   = 0;
  localparam int CNT_VALID   = 1;
  localparam int CNT_INVALID = 2;
  localparam int CNT_COPRIME = 3;
  localparam int CNT_ODD     = 4;
  localparam int CNT_ORDER   = 5;
  localparam int CNT_NUM     = 6;

  // Input action codes.
  localparam logic ACT_VALIDATE = 1'b0;
  localparam logic ACT_CLEAR    = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } cpv_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cpv_cmd_t;

  typedef struct packed {
    logic gcd_done;
  } cpv_status_t;

  typedef struct packed {
    logic                    pair_valid;
    logic [PORT_VALUE_W-1:0] common_divisor;
    logic                    gcd_is_one;
    logic                    both_odd_seen;
    logic                    order_holds;
    logic [PORT_COUNT_W-1:0] total_count;
    logic [PORT_COUNT_W-1:0] valid_count;
    logic [PORT_COUNT_W-1:0] invalid_count;
    logic [PORT_COUNT_W-1:0] coprime_fail_count;
    logic [PORT_COUNT_W-1:0] odd_fail_count;
    logic [PORT_COUNT_W-1:0] order_fail_count;
  } cpv_result_t;

  // Increment that holds at all ones instead of wrapping.
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] val);
    logic [COUNT_WIDTH-1:0] res;
    res = (val == {COUNT_WIDTH{1'b1}}) ? val : val + COUNT_WIDTH'(1);
    return res;
  endfunction

endpackage

### sv/cpv_ifs.sv
// ----------------------------------------------------------------------------
// Coprime pair validator channel interfaces
// Valid/ready channels for the pair words and the result words.
// ----------------------------------------------------------------------------
interface cpv_in_if import cpv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic [PORT_VALUE_W-1:0] parent_value;
  logic [PORT_VALUE_W-1:0] child_value;

  modport source (output valid, action, parent_value, child_value, input ready);
  modport sink   (input valid, action, parent_value, child_value, output ready);
endinterface

interface cpv_out_if import cpv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    pair_valid;
  logic [PORT_VALUE_W-1:0] common_divisor;
  logic                    gcd_is_one;
  logic                    both_odd_seen;
  logic                    order_holds;
  logic [PORT_COUNT_W-1:0] total_count;
  logic [PORT_COUNT_W-1:0] valid_count;
  logic [PORT_COUNT_W-1:0] invalid_count;
  logic [PORT_COUNT_W-1:0] coprime_fail_count;
  logic [PORT_COUNT_W-1:0] odd_fail_count;
  logic [PORT_COUNT_W-1:0] order_fail_count;

  modport source (output valid, pair_valid, common_divisor, gcd_is_one, both_odd_seen,
                  order_holds, total_count, valid_count, invalid_count,
                  coprime_fail_count, odd_fail_count, order_fail_count,
                  input ready);
  modport sink   (input valid, pair_valid, common_divisor, gcd_is_one, both_odd_seen,
                  order_holds, total_count, valid_count, invalid_count,
                  coprime_fail_count, odd_fail_count, order_fail_count,
                  output ready);
endinterface

### sv/cpv_ctrl.sv
// ----------------------------------------------------------------------------
// Coprime pair validator controller
// Sequences load, gcd steps and result hand-off, and owns the output valid.
// ----------------------------------------------------------------------------
module cpv_ctrl import cpv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  cpv_status_t status,
  output cpv_cmd_t    cmd
);

  cpv_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.gcd_done && (!out_valid_r || out_ready)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_RUN: begin
        cmd.step   = !status.gcd_done;
        cmd.finish = status.gcd_done && (!out_valid_r || out_ready);
      end
      default: cmd = '0;
    endcase
  end

  // The output word stays until taken; a new finish may refill it in the same cycle.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### sv/cpv_datapath.sv
// ----------------------------------------------------------------------------
// Coprime pair validator datapath
// Binary gcd unit, constraint flags, statistics counters and result register.
// ----------------------------------------------------------------------------
module cpv_datapath import cpv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cpv_cmd_t                cmd,
  input  logic                    in_action,
  input  logic [PORT_VALUE_W-1:0] in_parent_value,
  input  logic [PORT_VALUE_W-1:0] in_child_value,
  output cpv_status_t             status,
  output cpv_result_t             result
);

  logic [VALUE_WIDTH-1:0] a_r, a_nxt;
  logic [VALUE_WIDTH-1:0] b_r, b_nxt;
  logic [SHIFT_W-1:0]     k_r, k_nxt;
  logic                   clr_r, clr_nxt;
  logic                   odd_r, odd_nxt;
  logic                   ord_r, ord_nxt;

  logic [VALUE_WIDTH-1:0] p_val, q_val;
  logic [VALUE_WIDTH-1:0] big_val, small_val, diff_val;
  logic                   a_lt_b;

  logic [COUNT_WIDTH-1:0] cnt_r   [CNT_NUM];
  logic [COUNT_WIDTH-1:0] cnt_nxt [CNT_NUM];

  logic [VALUE_WIDTH-1:0] gcd_val;
  logic                   cop_val, valid_val;
  cpv_result_t            res_r, res_nxt;

  assign p_val = VALUE_WIDTH'(in_parent_value);
  assign q_val = VALUE_WIDTH'(in_child_value);

  // One subtract per step: larger odd value minus smaller odd value.
  assign a_lt_b    = a_r < b_r;
  assign big_val   = a_lt_b ? b_r : a_r;
  assign small_val = a_lt_b ? a_r : b_r;
  assign diff_val  = big_val - small_val;

  // Zero operands and clear words load equal values, so they finish at once.
  assign status.gcd_done = (a_r == b_r);

  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    k_nxt   = k_r;
    clr_nxt = clr_r;
    odd_nxt = odd_r;
    ord_nxt = ord_r;
    if (cmd.load) begin
      clr_nxt = (in_action == ACT_CLEAR);
      odd_nxt = p_val[0] & q_val[0];
      ord_nxt = (p_val > q_val) && (q_val != '0);
      k_nxt   = '0;
      if (in_action == ACT_CLEAR) begin
        a_nxt = '0;
        b_nxt = '0;
      end else if ((p_val == '0) || (q_val == '0)) begin
        a_nxt = p_val | q_val;
        b_nxt = p_val | q_val;
      end else begin
        a_nxt = p_val;
        b_nxt = q_val;
      end
    end else if (cmd.step) begin
      priority if (!a_r[0] && !b_r[0]) begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + SHIFT_W'(1);
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_lt_b) begin
        b_nxt = diff_val >> 1;
      end else begin
        a_nxt = diff_val >> 1;
      end
    end
  end

  assign gcd_val   = a_r << k_r;
  assign cop_val   = (a_r == VALUE_WIDTH'(1)) && (k_r == '0);
  assign valid_val = cop_val && !odd_r && ord_r;

  always_comb begin
    for (int i = 0; i < CNT_NUM; i++) begin
      cnt_nxt[i] = cnt_r[i];
    end
    if (cmd.finish) begin
      if (clr_r) begin
        for (int i = 0; i < CNT_NUM; i++) begin
          cnt_nxt[i] = '0;
        end
      end else begin
        cnt_nxt[CNT_TOTAL] = sat_inc(cnt_r[CNT_TOTAL]);
        if (valid_val) begin
          cnt_nxt[CNT_VALID] = sat_inc(cnt_r[CNT_VALID]);
        end else begin
          cnt_nxt[CNT_INVALID] = sat_inc(cnt_r[CNT_INVALID]);
          if (!cop_val) cnt_nxt[CNT_COPRIME] = sat_inc(cnt_r[CNT_COPRIME]);
          if (odd_r)    cnt_nxt[CNT_ODD]     = sat_inc(cnt_r[CNT_ODD]);
          if (!ord_r)   cnt_nxt[CNT_ORDER]   = sat_inc(cnt_r[CNT_ORDER]);
        end
      end
    end
  end

  always_comb begin
    res_nxt = res_r;
    if (cmd.finish) begin
      res_nxt.pair_valid         = !clr_r && valid_val;
      res_nxt.common_divisor     = clr_r ? '0 : PORT_VALUE_W'(gcd_val);
      res_nxt.gcd_is_one         = !clr_r && cop_val;
      res_nxt.both_odd_seen      = !clr_r && odd_r;
      res_nxt.order_holds        = !clr_r && ord_r;
      res_nxt.total_count        = PORT_COUNT_W'(cnt_nxt[CNT_TOTAL]);
      res_nxt.valid_count        = PORT_COUNT_W'(cnt_nxt[CNT_VALID]);
      res_nxt.invalid_count      = PORT_COUNT_W'(cnt_nxt[CNT_INVALID]);
      res_nxt.coprime_fail_count = PORT_COUNT_W'(cnt_nxt[CNT_COPRIME]);
      res_nxt.odd_fail_count     = PORT_COUNT_W'(cnt_nxt[CNT_ODD]);
      res_nxt.order_fail_count   = PORT_COUNT_W'(cnt_nxt[CNT_ORDER]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CNT_NUM; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < CNT_NUM; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    k_r   <= k_nxt;
    clr_r <= clr_nxt;
    odd_r <= odd_nxt;
    ord_r <= ord_nxt;
    res_r <= res_nxt;
  end

  assign result = res_r;

endmodule

### sv/coprime_pair_validator_core.sv
// ----------------------------------------------------------------------------
// Coprime pair validator core
// Checks (p, q) as a generator pair of a primitive Pythagorean triple and keeps
// saturating statistics; a clear word zeroes all statistics.
// ----------------------------------------------------------------------------
//  channel   direction  words per item  contents
//  in_ch     sink       1               action, parent_value p, child_value q
//  out_ch    source     1               flags, gcd, six statistics counters
//
// A word is accepted while the block is idle, then the binary gcd unit (one
// 64-bit compare, subtract and shift per cycle) runs until its two operands
// are equal, and a finish step writes the output register. A clear word, a
// pair with a zero value or a pair of equal values needs no steps.
// Reset is synchronous and active low; it zeroes the counters and empties the
// output register. A finished result waits in the output register while the
// next word is taken; a result whose output register is still full waits
// in the gcd unit until the downstream side takes the earlier word.
`include "coprime_pair_validator_core_defines.svh"

module coprime_pair_validator_core import cpv_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  cpv_in_if.sink   in_ch,
  cpv_out_if.source out_ch
);

  cpv_cmd_t    cmd;
  cpv_status_t status;
  cpv_result_t result;

  // The controller decides when to load, step and finish; it never sees data.
  cpv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the gcd operands, constraint flags, counters and the
  // registered result word.
  cpv_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_action       (in_ch.action),
    .in_parent_value (in_ch.parent_value),
    .in_child_value  (in_ch.child_value),
    .status          (status),
    .result          (result)
  );

  assign out_ch.pair_valid         = result.pair_valid;
  assign out_ch.common_divisor     = result.common_divisor;
  assign out_ch.gcd_is_one         = result.gcd_is_one;
  assign out_ch.both_odd_seen      = result.both_odd_seen;
  assign out_ch.order_holds        = result.order_holds;
  assign out_ch.total_count        = result.total_count;
  assign out_ch.valid_count        = result.valid_count;
  assign out_ch.invalid_count      = result.invalid_count;
  assign out_ch.coprime_fail_count = result.coprime_fail_count;
  assign out_ch.odd_fail_count     = result.odd_fail_count;
  assign out_ch.order_fail_count   = result.order_fail_count;

  // A result is only written once the gcd unit has converged.
  `CPV_ASSERT_SAME(a_finish_done, cmd.finish, status.gcd_done, "finish before gcd done")
  // Load, step and finish are mutually exclusive commands.
  `CPV_ASSERT_SAME(a_cmd_onehot, 1'b1, $onehot0({cmd.load, cmd.step, cmd.finish}),
    "overlapping datapath commands")
  // After a word is taken the block is busy in the following cycle.
  `CPV_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready,
    "input accepted while busy")
  // A finished item always shows up on the result channel next cycle.
  `CPV_ASSERT_NEXT(a_finish_shows, cmd.finish, out_ch.valid, "result not presented")

endmodule
